// ----- rtl/linear_contrast_stretch_macros.svh -----
// ---------------------------------------------------------------------------
// linear_contrast_stretch assertion macros
// Shared concurrent assertion forms, clocked on clk; all but LCS_ASSERT_NEXT_RST are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_CONTRAST_STRETCH_MACROS_SVH
`define LINEAR_CONTRAST_STRETCH_MACROS_SVH

// same-cycle implication, off during reset
`define LCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcs assertion failed");

// next-cycle implication, off during reset
`define LCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcs assertion failed");

// next-cycle implication, also checked through reset
`define LCS_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lcs assertion failed");

`endif

// ----- rtl/lcs_pkg.sv -----
// ---------------------------------------------------------------------------
// lcs_pkg
// Types, constants and helpers shared by the contrast stretch block.
// ---------------------------------------------------------------------------
package lcs_pkg;

  localparam int PIX_W     = 8;
  localparam int OFF_W     = 9;
  localparam int NUM_W     = 2 * PIX_W;
  localparam int SUM_W     = OFF_W + 1;
  localparam int DIV_STEPS = PIX_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // register map
  localparam logic REG_OFFSET = 1'b0;

  localparam logic signed [OFF_W-1:0] OFF_RESET = 9'sd50;
  localparam logic [PIX_W-1:0] MIN_RESET = 8'hFF;
  localparam logic [PIX_W-1:0] MAX_RESET = 8'h00;
  localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic last_step;
  } div_stat_t;

  // saturate a signed sum to one pixel
  function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/linear_contrast_stretch.sv -----
// ---------------------------------------------------------------------------
// linear_contrast_stretch
// Min/max contrast stretch of one frame held in an on-chip store.
// ---------------------------------------------------------------------------
// Load words (func 0) are taken while idle: the pixel is written to the frame
// store and the running min/max are updated; last_pixel closes the frame.
// Each drain word (func 1) then returns the next stored pixel as
// clamp((p - min) * 255 / (max - min) + brightness_offset), with a last flag
// on the final pixel. A drain word keeps the input busy through an
// accept/read step, a prep step, the radix-2 divider and a finish step;
// on a flat frame the divider is skipped. The finish step also waits
// while the output register is still full. A drain with nothing pending
// gives no result and drops the frame state; a load during drain is
// dropped. The store needs no clearing pass.
// brightness_offset is at byte address 0 of the APB port.
// ---------------------------------------------------------------------------
module linear_contrast_stretch import lcs_pkg::*; #(
  parameter int MAX_FRAME_PIXELS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_pixel_in,
  input  logic        in_last_pixel,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_out,
  output logic        out_last_out,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int CW = $clog2(MAX_FRAME_PIXELS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_PIXELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [PIX_W-1:0]        min_r, min_nxt;
  logic [PIX_W-1:0]        max_r, max_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           rp_r, rp_nxt;
  logic                    drain_r, drain_nxt;
  logic                    last_r, last_nxt;
  logic                    flat_r, flat_nxt;
  logic signed [OFF_W-1:0] off_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]        out_pix_r, out_pix_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    mem_wr, mem_rd;
  logic [PIX_W-1:0]        rd_data;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [PIX_W-1:0]        diff, span;
  logic                    flat_now;
  div_stat_t               div_stat;
  logic [PIX_W-1:0]        quot;
  logic [PIX_W-1:0]        q_sel;
  logic signed [SUM_W-1:0] sum;
  logic                    cfg_wr;
  logic [CW-1:0]           rp_inc;

  assign accept = in_valid && in_ready;
  assign rp_inc = CW'(rp_r + 1'b1);

  // prep-stage arithmetic: numerator (p - min) * 255 as (d << 8) - d
  assign diff     = PIX_W'(rd_data - min_r);
  assign span     = PIX_W'(max_r - min_r);
  assign flat_now = (max_r <= min_r);
  assign div_num  = NUM_W'({diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff});

  // finish-stage offset add
  assign q_sel = flat_r ? '0 : quot;
  assign sum   = $signed({2'b00, q_sel}) + $signed({off_r[OFF_W-1], off_r});

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    drain_nxt     = drain_r;
    last_nxt      = last_r;
    flat_nxt      = flat_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_LOAD) begin
            if (!drain_r) begin
              if (count_r < CNT_MAX) begin
                mem_wr    = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
                if (in_pixel_in < min_r) begin
                  min_nxt = in_pixel_in;
                end
                if (in_pixel_in > max_r) begin
                  max_nxt = in_pixel_in;
                end
              end
              if (in_last_pixel) begin
                drain_nxt = 1'b1;
                rp_nxt    = '0;
              end
            end
          end else if (drain_r && (rp_r < count_r)) begin
            mem_rd    = 1'b1;
            rp_nxt    = rp_inc;
            last_nxt  = (rp_inc >= count_r);
            state_nxt = S_PREP;
          end else begin
            // nothing pending: drop the frame state
            min_nxt   = MIN_RESET;
            max_nxt   = MAX_RESET;
            count_nxt = '0;
            rp_nxt    = '0;
            drain_nxt = 1'b0;
          end
        end
      end
      S_PREP: begin
        flat_nxt  = flat_now;
        div_start = !flat_now;
        state_nxt = flat_now ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (div_stat.last_step) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = clamp_pix(sum);
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
          if (last_r) begin
            min_nxt   = MIN_RESET;
            max_nxt   = MAX_RESET;
            count_nxt = '0;
            rp_nxt    = '0;
            drain_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      count_r     <= '0;
      rp_r        <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    flat_r     <= flat_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration register
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
               && (cfg_paddr[2] == REG_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= OFF_RESET;
    end else if (cfg_wr) begin
      off_r <= cfg_pwdata[OFF_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_OFFSET) ? 32'(off_r) : '0;

  lcs_frame_mem #(
    .DEPTH (MAX_FRAME_PIXELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_pixel_in),
    .rd_en   (mem_rd),
    .rd_addr (rp_r[AW-1:0]),
    .rd_data (rd_data)
  );

  lcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (span),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_last_out  = out_last_r;

endmodule

// ----- rtl/lcs_frame_mem.sv -----
// ---------------------------------------------------------------------------
// lcs_frame_mem
// Single-port-write, registered-read frame pixel store.
// ---------------------------------------------------------------------------
module lcs_frame_mem import lcs_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lcs_div.sv -----
// ---------------------------------------------------------------------------
// lcs_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// known to fit in one pixel, so only the low byte of the dividend is walked.
// ---------------------------------------------------------------------------
module lcs_div import lcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [PIX_W-1:0] den,
  output div_stat_t        stat,
  output logic [PIX_W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [PIX_W-1:0]  rem_r, rem_nxt;
  logic [PIX_W-1:0]  q_r, q_nxt;
  logic [PIX_W-1:0]  den_r, den_nxt;
  logic [PIX_W:0]    trial;
  logic              ge;

  // one trial subtract per step
  always_comb begin
    trial    = {rem_r, q_r[PIX_W-1]};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num[NUM_W-1:PIX_W];
      q_nxt    = num[PIX_W-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? PIX_W'(trial - {1'b0, den_r}) : trial[PIX_W-1:0];
      q_nxt   = {q_r[PIX_W-2:0], ge};
      cnt_nxt = STEP_W'(cnt_r + 1'b1);
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.last_step = busy_r && (cnt_r == STEP_W'(DIV_STEPS - 1));
  assign quot           = q_r;

endmodule

// ----- rtl/lcs_checker.sv -----
// ---------------------------------------------------------------------------
// lcs_checker
// Port-level checks for the contrast stretch block, bound to the top level.
// ---------------------------------------------------------------------------
`include "linear_contrast_stretch_macros.svh"

module lcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_out,
  input logic       out_last_out
);

  // a stalled result word holds
  `LCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_out) && $stable(out_last_out))

  // a load word never produces a result
  `LCS_ASSERT_NEXT(a_load_no_result, in_valid && in_ready && !in_func, !$rose(out_valid))

  // a new result only follows a busy cycle
  `LCS_ASSERT_IMPL(a_result_after_busy, $rose(out_valid), $past(!in_ready))

  // reset empties the output register
  `LCS_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind linear_contrast_stretch lcs_checker u_lcs_checker (.*);
